// ===== rtl/scsi_mode_sense_responder_core_macros.svh =====
// Assertion macros shared by the checkers of the MODE SENSE responder.
// Depends on nothing; included by the checker file.
`ifndef SCSI_MODE_SENSE_RESPONDER_CORE_MACROS_SVH
`define SCSI_MODE_SENSE_RESPONDER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMSR_ASSERT_SAME(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("smsr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SMSR_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("smsr assertion failed");

`endif

// ===== rtl/smsr_pkg.sv =====
// Constants for the MODE SENSE responder: register indexes, page codes and
// the sizes of the response sections. Depends on nothing.
package smsr_pkg;

    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_KIND = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY    = 1'd1;

    localparam logic [5:0] PAGE_ERROR_RECOVERY = 6'h01;
    localparam logic [5:0] PAGE_DISCONNECT     = 6'h02;
    localparam logic [5:0] PAGE_FORMAT         = 6'h03;
    localparam logic [5:0] PAGE_GEOMETRY       = 6'h04;
    localparam logic [5:0] PAGE_CACHING        = 6'h08;
    localparam logic [5:0] PAGE_ALL            = 6'h3F;

    localparam logic [1:0] PC_CHANGEABLE = 2'd1;

    localparam logic [6:0] HDR_LEN_SHORT = 7'd4;
    localparam logic [6:0] HDR_LEN_LONG  = 7'd8;
    localparam logic [6:0] BLK_DESC_LEN  = 7'd8;
    localparam logic [6:0] PAGE1_LEN     = 7'd12;
    localparam logic [6:0] PAGE2_LEN     = 7'd16;
    localparam logic [6:0] PAGE3_LEN     = 7'd24;
    localparam logic [6:0] PAGE4_LEN     = 7'd24;
    localparam logic [6:0] PAGE8_LEN     = 7'd12;

endpackage

// ===== rtl/scsi_mode_sense_responder_core.sv =====
// MODE SENSE response generator producing one response byte per beat.
// Depends on smsr_pkg for register indexes, page codes and section sizes.
//
// Usage: each input beat carries the decoded MODE SENSE fields and the
// offset of one response byte; each output beat returns that byte, its
// validity within the transfer, a last-byte mark, the transfer length and
// the missing-page flag. The configuration channel writes the device kind
// (index 0) and the capacity in blocks (index 1); it is always ready and
// should only be written while no beats are in flight.
// A beat is captured in the input register, its byte is selected by
// combinational logic, and the result is captured in the result register.
// Throughput: one beat per cycle while the receiver does not stall, set by
// the single pass of byte selection logic between the input and result registers.
// When the receiver stalls, the result is held and the input register keeps
// its beat; in_stall rises only when both registers are full.
// Reset clears the valid flags and both configuration registers.
module scsi_mode_sense_responder_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [smsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             ten_byte_form,
    input  logic                             no_block_descriptor,
    input  logic [1:0]                       page_control,
    input  logic [5:0]                       page_code,
    input  logic [7:0]                       alloc_high,
    input  logic [7:0]                       alloc_low,
    input  logic [6:0]                       byte_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       data_byte,
    output logic                             byte_valid,
    output logic                             last_byte,
    output logic [7:0]                       transfer_length,
    output logic                             page_missing
);

    function automatic logic [7:0] blk_desc_byte(input logic [2:0] off, input logic cd);
        logic [7:0] b;
        begin
            case (off)
                3'd0:    b = cd ? 8'h01 : 8'h00;
                3'd6:    b = 8'h02;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    function automatic logic [7:0] page_hdr_byte(input logic [4:0] off, input logic [7:0] code,
                                                 input logic [7:0] len);
        logic [7:0] b;
        begin
            case (off)
                5'd0:    b = code;
                5'd1:    b = len;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    function automatic logic [7:0] page3_byte(input logic [4:0] off, input logic chg);
        logic [7:0] b;
        begin
            case (off)
                5'd0:    b = 8'h03;
                5'd1:    b = 8'h16;
                5'd11:   b = chg ? 8'h00 : 8'h20;
                5'd12:   b = chg ? 8'h00 : 8'h02;
                5'd15:   b = chg ? 8'h00 : 8'h01;
                5'd20:   b = chg ? 8'h00 : 8'h40;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    function automatic logic [7:0] page4_byte(input logic [4:0] off, input logic chg,
                                              input logic [19:0] cyl);
        logic [7:0] b;
        begin
            case (off)
                5'd0:                b = 8'h04;
                5'd1:                b = 8'h16;
                5'd2, 5'd6, 5'd9:    b = chg ? 8'h00 : {4'h0, cyl[19:16]};
                5'd3, 5'd7, 5'd10:   b = chg ? 8'h00 : cyl[15:8];
                5'd4, 5'd8, 5'd11:   b = chg ? 8'h00 : cyl[7:0];
                5'd5:                b = chg ? 8'h00 : 8'h40;
                5'd13:               b = chg ? 8'h00 : 8'h01;
                5'd20:               b = chg ? 8'h00 : 8'h27;
                5'd21:               b = chg ? 8'h00 : 8'h10;
                default:             b = 8'h00;
            endcase
            return b;
        end
    endfunction

    logic        device_kind_reg;
    logic [31:0] capacity_reg;

    logic        in_vld_reg;
    logic        in_vld_next;
    logic        ten_reg;
    logic        dbd_reg;
    logic [1:0]  pc_reg;
    logic [5:0]  page_reg;
    logic [7:0]  ahi_reg;
    logic [7:0]  alo_reg;
    logic [6:0]  idx_reg;

    logic        out_vld_reg;
    logic        out_vld_next;
    logic [7:0]  data_reg;
    logic [7:0]  data_next;
    logic        bvalid_reg;
    logic        bvalid_next;
    logic        last_reg;
    logic        last_next;
    logic [7:0]  tl_reg;
    logic [7:0]  tl_next;
    logic        missing_reg;
    logic        missing_next;

    logic        out_adv;
    logic        in_take;

    logic        cd;
    logic        chg;
    logic        all_pages;
    logic        inc1;
    logic        inc2;
    logic        inc3;
    logic        inc4;
    logic        inc8;
    logic        found;
    logic [19:0] cyl;
    logic [6:0]  hdr_len;
    logic [6:0]  p1_start;
    logic [6:0]  p2_start;
    logic [6:0]  p3_start;
    logic [6:0]  p4_start;
    logic [6:0]  p8_start;
    logic [6:0]  resp_end;
    logic [7:0]  alloc_len;
    logic [7:0]  raw_byte;
    logic [6:0]  local_off;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_kind_reg <= 1'b0;
            capacity_reg    <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                smsr_pkg::CFG_DEVICE_KIND: device_kind_reg <= cfg_data[0];
                smsr_pkg::CFG_CAPACITY:    capacity_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign out_adv      = !out_vld_reg || !out_stall;
    assign in_stall     = in_vld_reg && !out_adv;
    assign in_take      = in_valid && !in_stall;
    assign in_vld_next  = in_take || (in_vld_reg && !out_adv);
    assign out_vld_next = out_adv ? in_vld_reg : out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ten_reg  <= ten_byte_form;
            dbd_reg  <= no_block_descriptor;
            pc_reg   <= page_control;
            page_reg <= page_code;
            ahi_reg  <= alloc_high;
            alo_reg  <= alloc_low;
            idx_reg  <= byte_index;
        end
        if (out_adv && in_vld_reg)
        begin
            data_reg    <= data_next;
            bvalid_reg  <= bvalid_next;
            last_reg    <= last_next;
            tl_reg      <= tl_next;
            missing_reg <= missing_next;
        end
    end

    // Section layout: header, optional block descriptor, then pages in
    // ascending order; each start is the end of the section before it.
    always_comb
    begin
        cd        = device_kind_reg;
        chg       = (pc_reg == smsr_pkg::PC_CHANGEABLE);
        all_pages = (page_reg == smsr_pkg::PAGE_ALL);
        inc1      = all_pages || (page_reg == smsr_pkg::PAGE_ERROR_RECOVERY);
        inc2      = all_pages || (page_reg == smsr_pkg::PAGE_DISCONNECT);
        inc3      = !cd && (all_pages || (page_reg == smsr_pkg::PAGE_FORMAT));
        inc4      = !cd && (all_pages || (page_reg == smsr_pkg::PAGE_GEOMETRY));
        inc8      = all_pages || (page_reg == smsr_pkg::PAGE_CACHING);
        found     = inc1 || inc2 || inc3 || inc4 || inc8;
        cyl       = capacity_reg[31:12] - 20'd1;

        hdr_len  = ten_reg ? smsr_pkg::HDR_LEN_LONG : smsr_pkg::HDR_LEN_SHORT;
        p1_start = hdr_len + (dbd_reg ? 7'd0 : smsr_pkg::BLK_DESC_LEN);
        p2_start = p1_start + (inc1 ? smsr_pkg::PAGE1_LEN : 7'd0);
        p3_start = p2_start + (inc2 ? smsr_pkg::PAGE2_LEN : 7'd0);
        p4_start = p3_start + (inc3 ? smsr_pkg::PAGE3_LEN : 7'd0);
        p8_start = p4_start + (inc4 ? smsr_pkg::PAGE4_LEN : 7'd0);
        resp_end = p8_start + (inc8 ? smsr_pkg::PAGE8_LEN : 7'd0);

        if (ten_reg && (ahi_reg != 8'd0))
        begin
            alloc_len = 8'hFF;
        end
        else
        begin
            alloc_len = alo_reg;
        end

        if (!found)
        begin
            tl_next = 8'd0;
        end
        else if ({1'b0, resp_end} > alloc_len)
        begin
            tl_next = alloc_len;
        end
        else
        begin
            tl_next = {1'b0, resp_end};
        end

        local_off = 7'd0;
        raw_byte  = 8'h00;
        if (idx_reg < hdr_len)
        begin
            if (ten_reg)
            begin
                case (idx_reg[2:0])
                    3'd1:    raw_byte = tl_next - 8'd2;
                    3'd2:    raw_byte = cd ? 8'h01 : 8'h00;
                    3'd3:    raw_byte = cd ? 8'h80 : 8'h00;
                    3'd7:    raw_byte = dbd_reg ? 8'h00 : 8'h08;
                    default: raw_byte = 8'h00;
                endcase
            end
            else
            begin
                case (idx_reg[1:0])
                    2'd0:    raw_byte = tl_next - 8'd1;
                    2'd3:    raw_byte = dbd_reg ? 8'h00 : 8'h08;
                    default: raw_byte = 8'h00;
                endcase
            end
        end
        else if (idx_reg < p1_start)
        begin
            local_off = idx_reg - hdr_len;
            raw_byte  = blk_desc_byte(local_off[2:0], cd);
        end
        else if (idx_reg < p2_start)
        begin
            local_off = idx_reg - p1_start;
            raw_byte  = page_hdr_byte(local_off[4:0], 8'h01, 8'h0A);
        end
        else if (idx_reg < p3_start)
        begin
            local_off = idx_reg - p2_start;
            raw_byte  = page_hdr_byte(local_off[4:0], 8'h02, 8'h0E);
        end
        else if (idx_reg < p4_start)
        begin
            local_off = idx_reg - p3_start;
            raw_byte  = page3_byte(local_off[4:0], chg);
        end
        else if (idx_reg < p8_start)
        begin
            local_off = idx_reg - p4_start;
            raw_byte  = page4_byte(local_off[4:0], chg, cyl);
        end
        else if (idx_reg < resp_end)
        begin
            local_off = idx_reg - p8_start;
            if (local_off[4:0] == 5'd2)
            begin
                raw_byte = chg ? 8'h00 : 8'h01;
            end
            else
            begin
                raw_byte = page_hdr_byte(local_off[4:0], 8'h08, 8'h0A);
            end
        end

        bvalid_next  = found && ({1'b0, idx_reg} < tl_next);
        last_next    = bvalid_next && (({1'b0, idx_reg} + 8'd1) == tl_next);
        data_next    = bvalid_next ? raw_byte : 8'h00;
        missing_next = !found;
    end

    assign out_valid       = out_vld_reg;
    assign data_byte       = data_reg;
    assign byte_valid      = bvalid_reg;
    assign last_byte       = last_reg;
    assign transfer_length = tl_reg;
    assign page_missing    = missing_reg;

endmodule

// ===== rtl/smsr_checker.sv =====
// Port-level checker for the MODE SENSE responder, bound to the responder core.
// Depends on scsi_mode_sense_responder_core_macros.svh and binds into scsi_mode_sense_responder_core.
`include "scsi_mode_sense_responder_core_macros.svh"

module smsr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] data_byte,
    input logic       byte_valid,
    input logic       last_byte,
    input logic [7:0] transfer_length,
    input logic       page_missing
);

    // A stalled result beat must stay put.
    `SMSR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(data_byte) && $stable(transfer_length))

    // With the result register empty the input side can never be stalled.
    `SMSR_ASSERT_SAME(a_no_idle_stall, clk, rst_n, !out_valid, !in_stall)

    // The final byte of a transfer is always a byte inside it.
    `SMSR_ASSERT_SAME(a_last_in_xfer, clk, rst_n, out_valid && last_byte,
        byte_valid && (transfer_length != 8'd0))

    // A missing page yields an empty transfer and no data.
    `SMSR_ASSERT_SAME(a_missing_empty, clk, rst_n, out_valid && page_missing,
        (transfer_length == 8'd0) && !byte_valid && (data_byte == 8'd0))

endmodule

bind scsi_mode_sense_responder_core smsr_checker u_smsr_checker (.*);

// ===== test/tb_scsi_mode_sense_responder_core.sv =====
// Self-checking testbench for the MODE SENSE responder core: a scoreboard class
// rebuilds each response image and checks every returned byte beat in order.
// Depends on smsr_pkg and scsi_mode_sense_responder_core only.
module tb_scsi_mode_sense_responder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASES         = 8;
    localparam int BEATS_PER_PHASE = 220;
    localparam int SHOW_LIMIT     = 40;

    typedef struct packed {
        logic       ten_form;
        logic       no_desc;
        logic [1:0] pc;
        logic [5:0] page;
        logic [7:0] alloc_hi;
        logic [7:0] alloc_lo;
        logic [6:0] byte_offset;
    } sense_command_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
        logic [7:0] transfer_length;
        logic       page_missing;
    } sense_result_t;

    class mode_sense_scoreboard;
        logic          cd_rom;
        logic [31:0]   capacity;
        sense_result_t expected_bytes[$];
        logic [7:0]    image[128];
        int unsigned   fill;
        int unsigned   checked;
        int unsigned   failures;
        int unsigned   missing_seen;
        int unsigned   last_seen;
        int unsigned   shown;

        function new();
            cd_rom       = 1'b0;
            capacity     = '0;
            checked      = 0;
            failures     = 0;
            missing_seen = 0;
            last_seen    = 0;
            shown        = 0;
        endfunction

        function void set_register(logic [smsr_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] value);
            if (idx == smsr_pkg::CFG_DEVICE_KIND)
            begin
                cd_rom = value[0];
            end
            else if (idx == smsr_pkg::CFG_CAPACITY)
            begin
                capacity = value;
            end
        endfunction

        function void emit(logic [7:0] value);
            if (fill < 128)
            begin
                image[fill] = value;
            end
            fill++;
        endfunction

        function void emit_zeros(int unsigned count);
            for (int unsigned i = 0; i < count; i++)
            begin
                emit(8'h00);
            end
        endfunction

        function sense_result_t predict_sense_byte(sense_command_t c);
            logic          chg;
            logic          every;
            logic          found;
            int unsigned   alloc;
            int unsigned   tl;
            logic [31:0]   last_block;
            logic [19:0]   cyl;
            sense_result_t r;

            chg   = (c.pc == smsr_pkg::PC_CHANGEABLE);
            every = (c.page == smsr_pkg::PAGE_ALL);
            found = 1'b0;
            fill  = 0;
            foreach (image[i])
            begin
                image[i] = 8'h00;
            end

            if (c.ten_form)
            begin
                alloc = (c.alloc_hi != 0) ? 255 : c.alloc_lo;
                emit(8'h00);
                emit(8'h00);
                emit(cd_rom ? 8'h01 : 8'h00);
                emit(cd_rom ? 8'h80 : 8'h00);
                emit_zeros(3);
                emit(c.no_desc ? 8'h00 : 8'h08);
            end
            else
            begin
                alloc = c.alloc_lo;
                emit_zeros(3);
                emit(c.no_desc ? 8'h00 : 8'h08);
            end

            if (!c.no_desc)
            begin
                emit(cd_rom ? 8'h01 : 8'h00);
                emit_zeros(5);
                emit(8'h02);
                emit(8'h00);
            end

            if (c.page == smsr_pkg::PAGE_ERROR_RECOVERY || every)
            begin
                found = 1'b1;
                emit(8'h01);
                emit(8'h0A);
                emit_zeros(10);
            end

            if (c.page == smsr_pkg::PAGE_DISCONNECT || every)
            begin
                found = 1'b1;
                emit(8'h02);
                emit(8'h0E);
                emit_zeros(14);
            end

            if (!cd_rom && (c.page == smsr_pkg::PAGE_FORMAT || every))
            begin
                found = 1'b1;
                emit(8'h03);
                emit(8'h16);
                emit_zeros(8);
                emit(8'h00);
                emit(chg ? 8'h00 : 8'd32);
                emit(chg ? 8'h00 : 8'h02);
                emit_zeros(2);
                emit(chg ? 8'h00 : 8'h01);
                emit_zeros(4);
                emit(chg ? 8'h00 : 8'h40);
                emit_zeros(3);
            end

            if (!cd_rom && (c.page == smsr_pkg::PAGE_GEOMETRY || every))
            begin
                last_block = (capacity & 32'hFFFF_F000) - 32'd1;
                cyl        = last_block[31:12];
                found      = 1'b1;
                emit(8'h04);
                emit(8'h16);
                for (int r3 = 0; r3 < 3; r3++)
                begin
                    emit(chg ? 8'h00 : {4'h0, cyl[19:16]});
                    emit(chg ? 8'h00 : cyl[15:8]);
                    emit(chg ? 8'h00 : cyl[7:0]);
                    if (r3 == 0)
                    begin
                        emit(chg ? 8'h00 : 8'h40);
                    end
                end
                emit(8'h00);
                emit(chg ? 8'h00 : 8'h01);
                emit_zeros(6);
                emit(chg ? 8'h00 : 8'h27);
                emit(chg ? 8'h00 : 8'h10);
                emit_zeros(2);
            end

            if (c.page == smsr_pkg::PAGE_CACHING || every)
            begin
                found = 1'b1;
                emit(8'h08);
                emit(8'h0A);
                emit(chg ? 8'h00 : 8'h01);
                emit_zeros(9);
            end

            tl = 0;
            if (found)
            begin
                tl = (fill > alloc) ? alloc : fill;
                if (c.ten_form)
                begin
                    image[1] = 8'(tl - 2);
                end
                else
                begin
                    image[0] = 8'(tl - 1);
                end
            end

            r.byte_valid      = found && (c.byte_offset < tl);
            r.data_byte       = r.byte_valid ? image[c.byte_offset] : 8'h00;
            r.last_byte       = r.byte_valid && (c.byte_offset + 1 == tl);
            r.transfer_length = 8'(tl);
            r.page_missing    = !found;
            return r;
        endfunction

        function void note_command(sense_command_t c);
            expected_bytes.push_back(predict_sense_byte(c));
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void report_mismatch(string field, int unsigned want, int unsigned got);
            failures++;
            if (shown < SHOW_LIMIT)
            begin
                shown++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want,
                         got);
            end
        endfunction

        function void check_result(sense_result_t got);
            sense_result_t want;

            if (expected_bytes.size() == 0)
            begin
                failures++;
                $display("%0t: result beat with nothing expected, expected none, actual 0x%0h",
                         $time, got);
                return;
            end
            want = expected_bytes.pop_front();
            checked++;
            if (want.page_missing)
            begin
                missing_seen++;
            end
            if (want.last_byte)
            begin
                last_seen++;
            end
            if (got.data_byte !== want.data_byte)
            begin
                report_mismatch("data_byte", want.data_byte, got.data_byte);
            end
            if (got.byte_valid !== want.byte_valid)
            begin
                report_mismatch("byte_valid", want.byte_valid, got.byte_valid);
            end
            if (got.last_byte !== want.last_byte)
            begin
                report_mismatch("last_byte", want.last_byte, got.last_byte);
            end
            if (got.transfer_length !== want.transfer_length)
            begin
                report_mismatch("transfer_length", want.transfer_length, got.transfer_length);
            end
            if (got.page_missing !== want.page_missing)
            begin
                report_mismatch("page_missing", want.page_missing, got.page_missing);
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [smsr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]                      cfg_data;
    logic                             in_valid;
    logic                             in_stall;
    logic                             ten_byte_form;
    logic                             no_block_descriptor;
    logic [1:0]                       page_control;
    logic [5:0]                       page_code;
    logic [7:0]                       alloc_high;
    logic [7:0]                       alloc_low;
    logic [6:0]                       byte_index;
    logic                             out_valid;
    logic                             out_stall;
    logic [7:0]                       data_byte;
    logic                             byte_valid;
    logic                             last_byte;
    logic [7:0]                       transfer_length;
    logic                             page_missing;

    mode_sense_scoreboard book = new();
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cycle_count;
    int unsigned settings_used;

    scsi_mode_sense_responder_core u_dut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .ten_byte_form       (ten_byte_form),
        .no_block_descriptor (no_block_descriptor),
        .page_control        (page_control),
        .page_code           (page_code),
        .alloc_high          (alloc_high),
        .alloc_low           (alloc_low),
        .byte_index          (byte_index),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .data_byte           (data_byte),
        .byte_valid          (byte_valid),
        .last_byte           (last_byte),
        .transfer_length     (transfer_length),
        .page_missing        (page_missing)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("scsi_mode_sense_responder_core regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall = rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            book.check_result({data_byte, byte_valid, last_byte, transfer_length,
                               page_missing});
        end
    end

    function automatic sense_command_t make_command(logic ten, logic dbd, logic [1:0] pc,
                                                    logic [5:0] page, logic [7:0] ahi,
                                                    logic [7:0] alo, logic [6:0] idx);
        sense_command_t c;

        c.ten_form    = ten;
        c.no_desc     = dbd;
        c.pc          = pc;
        c.page        = page;
        c.alloc_hi    = ahi;
        c.alloc_lo    = alo;
        c.byte_offset = idx;
        return c;
    endfunction

    function automatic sense_command_t random_command();
        sense_command_t c;

        c.ten_form = 1'($urandom_range(0, 1));
        c.no_desc  = 1'($urandom_range(0, 1));
        c.pc       = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 8)
        begin
            case ($urandom_range(0, 5))
                0: c.page = smsr_pkg::PAGE_ERROR_RECOVERY;
                1: c.page = smsr_pkg::PAGE_DISCONNECT;
                2: c.page = smsr_pkg::PAGE_FORMAT;
                3: c.page = smsr_pkg::PAGE_GEOMETRY;
                4: c.page = smsr_pkg::PAGE_CACHING;
                default: c.page = smsr_pkg::PAGE_ALL;
            endcase
        end
        else
        begin
            c.page = 6'($urandom_range(0, 63));
        end
        c.alloc_hi = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
        case ($urandom_range(0, 3))
            0: c.alloc_lo = 8'hFF;
            1: c.alloc_lo = 8'($urandom_range(0, 255));
            default: c.alloc_lo = 8'($urandom_range(0, 120));
        endcase
        c.byte_offset = 7'($urandom_range(0, 127));
        return c;
    endfunction

    task automatic send_command(input sense_command_t c);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid            = 1'b1;
        ten_byte_form       = c.ten_form;
        no_block_descriptor = c.no_desc;
        page_control        = c.pc;
        page_code           = c.page;
        alloc_high          = c.alloc_hi;
        alloc_low           = c.alloc_lo;
        byte_index          = c.byte_offset;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        book.note_command(c);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (book.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [smsr_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [31:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        book.set_register(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        sense_command_t directed[$];
        sense_command_t c;
        logic           kinds[PHASES];
        logic [31:0]    sizes[PHASES];
        int             sent;
        int             first;
        int             stop;
        bit             paused;

        rst_n               = 1'b0;
        cfg_valid           = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        in_valid            = 1'b0;
        out_stall           = 1'b0;
        ten_byte_form       = 1'b0;
        no_block_descriptor = 1'b0;
        page_control        = '0;
        page_code           = '0;
        alloc_high          = '0;
        alloc_low           = '0;
        byte_index          = '0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        cycle_count         = 0;
        settings_used       = 0;

        kinds = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
        sizes = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), 32'd4095, 32'd4096,
                  $urandom(), 32'h0001_2000 + $urandom_range(0, 4095), 32'hFFFF_FFFF};

        directed.push_back(make_command(0, 0, 0, smsr_pkg::PAGE_ALL, 0, 255, 0));
        directed.push_back(make_command(0, 0, 0, smsr_pkg::PAGE_ALL, 0, 255, 3));
        directed.push_back(make_command(1, 0, 0, smsr_pkg::PAGE_ALL, 1, 0, 1));
        directed.push_back(make_command(1, 0, 0, smsr_pkg::PAGE_ALL, 8'hFF, 8'hFF, 103));
        directed.push_back(make_command(1, 0, 0, smsr_pkg::PAGE_ALL, 0, 0, 0));
        directed.push_back(make_command(1, 1, 0, smsr_pkg::PAGE_ALL, 0, 1, 0));
        directed.push_back(make_command(0, 0, 0, smsr_pkg::PAGE_CACHING, 8'hFF, 4, 3));
        directed.push_back(make_command(0, 0, 0, smsr_pkg::PAGE_GEOMETRY, 0, 255, 14));
        directed.push_back(make_command(0, 0, smsr_pkg::PC_CHANGEABLE,
                                        smsr_pkg::PAGE_GEOMETRY, 0, 255, 14));
        directed.push_back(make_command(0, 0, 2, smsr_pkg::PAGE_FORMAT, 0, 255, 23));
        directed.push_back(make_command(0, 0, 3, smsr_pkg::PAGE_FORMAT, 0, 255, 23));
        directed.push_back(make_command(0, 0, smsr_pkg::PC_CHANGEABLE,
                                        smsr_pkg::PAGE_CACHING, 0, 255, 14));
        directed.push_back(make_command(1, 0, smsr_pkg::PC_CHANGEABLE,
                                        smsr_pkg::PAGE_ALL, 0, 255, 60));
        directed.push_back(make_command(0, 0, 0, 6'h05, 0, 255, 0));
        directed.push_back(make_command(0, 1, 0, 6'h00, 0, 255, 2));
        directed.push_back(make_command(1, 1, 3, 6'h3E, 8'h80, 255, 127));
        directed.push_back(make_command(0, 1, 0, smsr_pkg::PAGE_ERROR_RECOVERY, 0, 255, 4));
        directed.push_back(make_command(1, 1, 0, smsr_pkg::PAGE_DISCONNECT, 0, 255, 127));
        directed.push_back(make_command(1, 1, 0, smsr_pkg::PAGE_DISCONNECT, 0, 255, 23));
        directed.push_back(make_command(0, 0, 0, smsr_pkg::PAGE_ALL, 0, 255, 99));

        repeat (7)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            repeat (4)
            begin
                @(posedge clk);
            end
            write_register(smsr_pkg::CFG_DEVICE_KIND, {31'd0, kinds[p]});
            write_register(smsr_pkg::CFG_CAPACITY, sizes[p]);
            settings_used++;

            case (p * 3 / PHASES)
                0:
                begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 59;
                end
                1:
                begin
                    send_idle_pct  = 59;
                    recv_stall_pct = 30;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            if (p == 0)
            begin
                foreach (directed[i])
                begin
                    send_command(directed[i]);
                end
            end

            sent   = 0;
            paused = 1'b0;
            while (sent < BEATS_PER_PHASE)
            begin
                if (!paused && sent >= BEATS_PER_PHASE / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                c = random_command();
                if ($urandom_range(0, 9) < 7)
                begin
                    first = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 0;
                    stop  = first + $urandom_range(0, 100);
                    if (stop > 127)
                    begin
                        stop = 127;
                    end
                    for (int o = first; o <= stop && sent < BEATS_PER_PHASE; o++)
                    begin
                        c.byte_offset = 7'(o);
                        send_command(c);
                        sent++;
                    end
                end
                else
                begin
                    send_command(c);
                    sent++;
                end
            end
        end

        drain_results();
        repeat (10)
        begin
            @(posedge clk);
        end

        $display("Checked %0d result beats under %0d register settings, both device kinds.",
                 book.checked, settings_used);
        $display("Of these, %0d had no matching page and %0d carried the last-byte mark.",
                 book.missing_seen, book.last_seen);
        if (book.failures == 0 && book.pending() == 0)
        begin
            $display("scsi_mode_sense_responder_core regression: pass");
        end
        else
        begin
            $display("scsi_mode_sense_responder_core regression: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/smsr_pkg.sv
rtl/scsi_mode_sense_responder_core.sv
rtl/smsr_checker.sv
test/tb_scsi_mode_sense_responder_core.sv
